### rtl/rpis_pkg.sv
// ----------------------------------------------------------------------------
// rpis_pkg
// Shared widths, codes and types of the RANSAC plane inlier search block.
// ----------------------------------------------------------------------------
package rpis_pkg;

  // coordinate and arithmetic widths
  localparam int COORD_BITS = 16;
  localparam int POINT_W    = 3 * COORD_BITS;
  localparam int DIFF_W     = COORD_BITS + 1;      // difference of two coords
  localparam int NRM_W      = 2 * DIFF_W + 1;      // signed normal component
  localparam int MAGN_W     = 2 * DIFF_W;          // normal component magnitude
  localparam int NORM_W     = 2 * MAGN_W + 2;      // a*a+b*b+c*c
  localparam int PROD_W     = NRM_W + DIFF_W;      // one term of the dot product
  localparam int DOT_W      = PROD_W + 2;          // signed dot product
  localparam int MAG_W      = DOT_W - 1;           // its magnitude
  localparam int SQ_W       = 2 * MAG_W;           // squared distance term
  localparam int CMP_W      = SQ_W;                // threshold compare width

  // field and register widths
  localparam int OP_W   = 2;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int ST_W   = 2;
  localparam int TOL_W  = 16;
  localparam int TOL2_W = 2 * TOL_W;
  localparam int NPT_W  = 11;
  localparam int TRL_W  = 16;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;
  localparam int IN_DW  = 88;
  localparam int OUT_DW = 32;

  localparam int MAX_POINTS_DEF = 1024;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_TRIAL = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_START = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD   = 2'd1;
  localparam logic [ST_W-1:0] ST_LIMIT = 2'd2;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_TOL  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_NPTS = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_TLIM = 2'd2;

  // reset values
  localparam logic [TOL_W-1:0] TOL_RST  = 16'd200;
  localparam logic [NPT_W-1:0] NPTS_RST = 11'd1024;
  localparam logic [TRL_W-1:0] TLIM_RST = 16'd100;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] z;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } point_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] a;
    logic signed [NRM_W-1:0] b;
    logic signed [NRM_W-1:0] c;
    logic [CMP_W-1:0]        thr;
  } plane_t;

  // per-point flags that ride along the distance pipeline
  typedef struct packed {
    logic       samp;
    logic       act;
    logic [1:0] marks;
  } tag_t;

endpackage

### rtl/rpis_ram.sv
// ----------------------------------------------------------------------------
// rpis_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rpis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/rpis_plane_setup.sv
// ----------------------------------------------------------------------------
// rpis_plane_setup
// Plane from three samples: cross product, then a*a+b*b+c*c and the
// threshold norm*tol^2 on one shared 17 x 32 multiply-accumulate.
// ----------------------------------------------------------------------------
module rpis_plane_setup (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  rpis_pkg::point_t              p1,
  input  rpis_pkg::point_t              p2,
  input  rpis_pkg::point_t              p3,
  input  logic [rpis_pkg::TOL2_W-1:0]   tol2,
  output logic                          done,
  output rpis_pkg::plane_t              plane
);

  localparam int DW     = rpis_pkg::DIFF_W;
  localparam int NW     = rpis_pkg::NRM_W;
  localparam int MW     = rpis_pkg::MAGN_W;
  localparam int HW     = MW / 2;
  localparam int RW     = rpis_pkg::NORM_W;
  localparam int CW     = rpis_pkg::CMP_W;
  localparam int TW     = rpis_pkg::TOL2_W;
  localparam int PW     = DW + TW;
  localparam int NCHUNK = (RW + DW - 1) / DW;

  localparam int ST_CROSS = 0;
  localparam int ST_N0    = 1;
  localparam int ST_NEND  = ST_N0 + 9;
  localparam int ST_T0    = ST_NEND + 1;
  localparam int ST_TEND  = ST_T0 + NCHUNK;
  localparam int ST_DONE  = ST_TEND + 1;

  logic                 busy_r;
  logic [4:0]           stp_r;
  logic signed [DW-1:0] x21_r, y21_r, z21_r, x31_r, y31_r, z31_r;
  logic signed [NW-1:0] a_r, b_r, c_r;
  logic [RW-1:0]        nrm_r;
  logic [CW-1:0]        thr_r;
  logic [PW-1:0]        prod_r;
  logic [6:0]           sh_r;
  logic                 pv_r;
  logic                 tgt_r;
  logic                 done_r;

  logic signed [NW-1:0]   na, nb, nc;
  logic [MW-1:0]          ma, mb, mc, msel;
  logic [3:0]             nk;
  logic [2:0]             tj;
  logic [1:0]             comp, part;
  logic [NCHUNK*DW-1:0]   nrm_pad;
  logic [DW-1:0]          opa;
  logic [TW-1:0]          opb;
  logic [6:0]             sh;
  logic                   is_norm, is_thr;

  always_comb begin
    na = -a_r;
    nb = -b_r;
    nc = -c_r;
    ma = a_r[NW-1] ? na[MW-1:0] : a_r[MW-1:0];
    mb = b_r[NW-1] ? nb[MW-1:0] : b_r[MW-1:0];
    mc = c_r[NW-1] ? nc[MW-1:0] : c_r[MW-1:0];
    nk = 4'(stp_r - 5'(ST_N0));
    tj = 3'(stp_r - 5'(ST_T0));
    is_norm = (stp_r >= 5'(ST_N0)) && (stp_r < 5'(ST_NEND));
    is_thr  = (stp_r >= 5'(ST_T0)) && (stp_r < 5'(ST_TEND));
    if (nk < 4'd3) begin
      comp = 2'd0;
    end else if (nk < 4'd6) begin
      comp = 2'd1;
    end else begin
      comp = 2'd2;
    end
    part = 2'(nk - 4'(comp) * 4'd3);
    case (comp)
      2'd0:    msel = ma;
      2'd1:    msel = mb;
      default: msel = mc;
    endcase
    nrm_pad = (NCHUNK*DW)'(nrm_r);
    opa = '0;
    opb = '0;
    sh  = '0;
    if (is_norm) begin
      case (part)
        2'd0: begin
          opa = DW'(msel[MW-1:HW]);
          opb = TW'(msel[MW-1:HW]);
          sh  = 7'(2 * HW);
        end
        2'd1: begin
          opa = DW'(msel[MW-1:HW]);
          opb = TW'(msel[HW-1:0]);
          sh  = 7'(HW + 1);
        end
        default: begin
          opa = DW'(msel[HW-1:0]);
          opb = TW'(msel[HW-1:0]);
          sh  = 7'd0;
        end
      endcase
    end else if (is_thr) begin
      opa = nrm_pad[tj*DW +: DW];
      opb = tol2;
      sh  = 7'(tj * DW);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      stp_r  <= '0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      pv_r   <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        stp_r  <= '0;
        x21_r  <= DW'(p2.x) - DW'(p1.x);
        y21_r  <= DW'(p2.y) - DW'(p1.y);
        z21_r  <= DW'(p2.z) - DW'(p1.z);
        x31_r  <= DW'(p3.x) - DW'(p1.x);
        y31_r  <= DW'(p3.y) - DW'(p1.y);
        z31_r  <= DW'(p3.z) - DW'(p1.z);
        nrm_r  <= '0;
        thr_r  <= '0;
      end else if (busy_r) begin
        stp_r <= stp_r + 5'd1;
        if (stp_r == 5'(ST_CROSS)) begin
          a_r <= NW'(y21_r * z31_r) - NW'(z21_r * y31_r);
          b_r <= NW'(z21_r * x31_r) - NW'(x21_r * z31_r);
          c_r <= NW'(x21_r * y31_r) - NW'(y21_r * x31_r);
        end
        if (is_norm || is_thr) begin
          prod_r <= PW'(opa) * PW'(opb);
          sh_r   <= sh;
          tgt_r  <= is_thr;
          pv_r   <= 1'b1;
        end
        if (stp_r == 5'(ST_DONE)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
      // accumulate the registered product in the following cycle
      if (pv_r) begin
        if (tgt_r) begin
          thr_r <= thr_r + (CW'(prod_r) << sh_r);
        end else begin
          nrm_r <= nrm_r + (RW'(prod_r) << sh_r);
        end
      end
    end
  end

  assign done      = done_r;
  assign plane.a   = a_r;
  assign plane.b   = b_r;
  assign plane.c   = c_r;
  assign plane.thr = thr_r;

endmodule

### rtl/rpis_dist_pipe.sv
// ----------------------------------------------------------------------------
// rpis_dist_pipe
// Five-stage distance pipeline: one point per cycle in, inlier mark out.
// ----------------------------------------------------------------------------
module rpis_dist_pipe #(
  parameter int AW = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_v,
  input  logic [AW-1:0]     in_idx,
  input  rpis_pkg::tag_t    in_tag,
  input  rpis_pkg::point_t  q,
  input  rpis_pkg::point_t  p1,
  input  rpis_pkg::plane_t  plane,
  output logic              out_v,
  output logic [AW-1:0]     out_idx,
  output rpis_pkg::tag_t    out_tag,
  output logic              out_hit
);

  localparam int DW = rpis_pkg::DIFF_W;
  localparam int PW = rpis_pkg::PROD_W;
  localparam int RW = rpis_pkg::DOT_W;
  localparam int MW = rpis_pkg::MAG_W;
  localparam int HM = (MW + 1) / 2;
  localparam int SW = rpis_pkg::SQ_W;

  logic [4:0]           v_r;
  logic [AW-1:0]        idx_r [5];
  rpis_pkg::tag_t       tag_r [5];
  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  logic signed [PW-1:0] tx_r, ty_r, tz_r;
  logic [MW-1:0]        rm_r;
  logic [2*HM-1:0]      hh_r, hl_r, ll_r;
  logic [SW-1:0]        sq_r;

  logic signed [RW-1:0] r_sum, r_neg;
  logic [HM-1:0]        rm_hi, rm_lo;

  always_comb begin
    r_sum = RW'(tx_r) + RW'(ty_r) + RW'(tz_r);
    r_neg = -r_sum;
    rm_hi = HM'(rm_r[MW-1:HM]);
    rm_lo = rm_r[HM-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    idx_r[0] <= in_idx;
    tag_r[0] <= in_tag;
    for (int s = 1; s < 5; s++) begin
      idx_r[s] <= idx_r[s-1];
      tag_r[s] <= tag_r[s-1];
    end
    dx_r <= DW'(q.x) - DW'(p1.x);
    dy_r <= DW'(q.y) - DW'(p1.y);
    dz_r <= DW'(q.z) - DW'(p1.z);
    tx_r <= PW'(plane.a * dx_r);
    ty_r <= PW'(plane.b * dy_r);
    tz_r <= PW'(plane.c * dz_r);
    rm_r <= r_sum[RW-1] ? r_neg[MW-1:0] : r_sum[MW-1:0];
    // square the magnitude in halves
    hh_r <= (2*HM)'(rm_hi) * (2*HM)'(rm_hi);
    hl_r <= (2*HM)'(rm_hi) * (2*HM)'(rm_lo);
    ll_r <= (2*HM)'(rm_lo) * (2*HM)'(rm_lo);
    sq_r <= (SW'(hh_r) << (2 * HM)) + (SW'(hl_r) << (HM + 1)) + SW'(ll_r);
  end

  assign out_v   = v_r[4];
  assign out_idx = idx_r[4];
  assign out_tag = tag_r[4];
  assign out_hit = tag_r[4].act && (tag_r[4].samp || (sq_r < plane.thr));

endmodule

### rtl/ransac_plane_inlier_search.sv
// ----------------------------------------------------------------------------
// ransac_plane_inlier_search
// Point store, plane trials over all points and query of the best inlier set.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per operation; in_tuser carries the op code (load, trial,
//           query, start), in_tdata the index, coordinates and sample slots.
//   out_* : exactly one result beat per input beat, in order.
//   cfg_* : plain register writes (tolerance, point count, trial limit), to be
//           made while the block is idle; the block itself does not enforce it.
// Sequencing:
//   load, start and every rejected op answer from the idle state; a query
//   first reads the mark memory (S_QRY). A trial reads its three samples
//   (S_RD), launches (S_GO), sets up the plane on the shared multiply-accumulate
//   (S_SET), reads one point per cycle from the point memory through the
//   5-stage distance pipeline, writing each mark back (S_WALK), and drains
//   (S_DRAIN). One operation is in flight at a time; in_tready is low meanwhile.
// Reset clears the best set and trial counter, presets the registers; the point
// and mark memories are not cleared. While out_tready is low a result beat
// holds, and one more input beat is taken only once that result is taken.
// ----------------------------------------------------------------------------
module ransac_plane_inlier_search #(
  parameter int MAX_POINTS = rpis_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // point_index, coord_x, coord_y, coord_z, sample_first, sample_second,
  // sample_third
  input  logic [rpis_pkg::IN_DW-1:0]   in_tdata,
  // op
  input  logic [rpis_pkg::OP_W-1:0]    in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // trial_count, best_count, is_inlier, status, zero fill
  output logic [rpis_pkg::OUT_DW-1:0]  out_tdata,
  input  logic                         cfg_we,
  input  logic [rpis_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [rpis_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = (AW + 1 > rpis_pkg::CNT_W) ? AW + 1 : rpis_pkg::CNT_W;
  localparam logic [NW-1:0] MAX_N  = NW'(MAX_POINTS);
  localparam logic [AW-1:0] LAST_A = AW'(MAX_POINTS - 1);
  localparam int CB = rpis_pkg::COORD_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_GO    = 3'd2;
  localparam logic [2:0] S_SET   = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_QRY   = 3'd6;

  logic [2:0]                     state_r;
  logic [rpis_pkg::TOL_W-1:0]     tol_r;
  logic [rpis_pkg::NPT_W-1:0]     npts_r;
  logic [rpis_pkg::TRL_W-1:0]     tlim_r;
  logic [rpis_pkg::TOL2_W-1:0]    tol2_r;
  logic [NW-1:0]                  best_r;
  logic                           bank_r;
  logic [rpis_pkg::TRL_W-1:0]     trials_r;
  logic [NW-1:0]                  cnt_r;
  logic [AW-1:0]                  wcnt_r;
  logic                           rdv_r;
  logic [AW-1:0]                  ridx_r;
  logic [1:0]                     rdc_r;
  logic [NW-1:0]                  s1_r, s2_r, s3_r;
  rpis_pkg::point_t               p1_r, p2_r, p3_r;
  logic                           out_v_r;
  logic [rpis_pkg::CNT_W-1:0]     o_tc_r, o_best_r;
  logic                           o_inl_r;
  logic [rpis_pkg::ST_W-1:0]      o_st_r;

  // input unpacking
  logic [rpis_pkg::OP_W-1:0]  op;
  logic [rpis_pkg::IDX_W-1:0] f_idx, f_s1, f_s2, f_s3;
  rpis_pkg::point_t           f_pt;
  logic [NW-1:0]              idx_n, s1_n, s2_n, s3_n, nact, tc_fin;
  logic                       in_acc, idx_ok, smp_bad;

  // memory and pipeline wiring
  logic                 pt_we, mk_we, su_start, su_done;
  logic [AW-1:0]        pt_raddr, mk_raddr;
  logic [1:0]           mk_wdata, mk_rdata;
  rpis_pkg::point_t     pt_rdata;
  rpis_pkg::plane_t     plane;
  rpis_pkg::tag_t       p_tag, po_tag;
  logic                 po_v, po_hit;
  logic [AW-1:0]        po_idx;

  assign op       = in_tuser;
  assign f_idx    = in_tdata[9:0];
  assign f_pt.x   = in_tdata[10 +: CB];
  assign f_pt.y   = in_tdata[26 +: CB];
  assign f_pt.z   = in_tdata[42 +: CB];
  assign f_s1     = in_tdata[67:58];
  assign f_s2     = in_tdata[77:68];
  assign f_s3     = in_tdata[87:78];

  assign in_tready = (state_r == S_IDLE) && (!out_v_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    idx_n  = NW'(f_idx);
    s1_n   = NW'(f_s1);
    s2_n   = NW'(f_s2);
    s3_n   = NW'(f_s3);
    nact   = (NW'(npts_r) > MAX_N) ? MAX_N : NW'(npts_r);
    idx_ok = idx_n < MAX_N;
    smp_bad = (s1_n >= nact) || (s2_n >= nact) || (s3_n >= nact) ||
              (s1_n == s2_n) || (s1_n == s3_n) || (s2_n == s3_n);
    tc_fin = cnt_r + NW'(po_hit);
  end

  // memory addressing
  always_comb begin
    pt_we = in_acc && (op == rpis_pkg::OP_LOAD) && idx_ok;
    case (state_r)
      S_RD: begin
        case (rdc_r)
          2'd0:    pt_raddr = s1_r[AW-1:0];
          2'd1:    pt_raddr = s2_r[AW-1:0];
          default: pt_raddr = s3_r[AW-1:0];
        endcase
      end
      default: pt_raddr = wcnt_r;
    endcase
    mk_raddr = (state_r == S_IDLE) ? idx_n[AW-1:0] : wcnt_r;
    mk_we    = po_v;
    // replace the working bank bit, keep the best bank bit
    mk_wdata = bank_r ? {po_tag.marks[1], po_hit} : {po_hit, po_tag.marks[0]};
    su_start = (state_r == S_GO);
    p_tag.samp  = (NW'(ridx_r) == s1_r) || (NW'(ridx_r) == s2_r) ||
                  (NW'(ridx_r) == s3_r);
    p_tag.act   = NW'(ridx_r) < nact;
    p_tag.marks = mk_rdata;
  end

  rpis_ram #(.WIDTH(rpis_pkg::POINT_W), .DEPTH(MAX_POINTS)) u_points (
    .clk   (clk),
    .we    (pt_we),
    .waddr (idx_n[AW-1:0]),
    .wdata (f_pt),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  rpis_ram #(.WIDTH(2), .DEPTH(MAX_POINTS)) u_marks (
    .clk   (clk),
    .we    (mk_we),
    .waddr (po_idx),
    .wdata (mk_wdata),
    .raddr (mk_raddr),
    .rdata (mk_rdata)
  );

  rpis_plane_setup u_setup (
    .clk   (clk),
    .rst_n (rst_n),
    .start (su_start),
    .p1    (p1_r),
    .p2    (p2_r),
    .p3    (p3_r),
    .tol2  (tol2_r),
    .done  (su_done),
    .plane (plane)
  );

  rpis_dist_pipe #(.AW(AW)) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (rdv_r),
    .in_idx  (ridx_r),
    .in_tag  (p_tag),
    .q       (pt_rdata),
    .p1      (p1_r),
    .plane   (plane),
    .out_v   (po_v),
    .out_idx (po_idx),
    .out_tag (po_tag),
    .out_hit (po_hit)
  );

  always_ff @(posedge clk) begin
    tol2_r <= rpis_pkg::TOL2_W'(tol_r) * rpis_pkg::TOL2_W'(tol_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tol_r    <= rpis_pkg::TOL_RST;
      npts_r   <= rpis_pkg::NPTS_RST;
      tlim_r   <= rpis_pkg::TLIM_RST;
      best_r   <= '0;
      bank_r   <= 1'b0;
      trials_r <= '0;
      rdv_r    <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rpis_pkg::CFG_TOL:  tol_r  <= cfg_wdata;
          rpis_pkg::CFG_NPTS: npts_r <= cfg_wdata[rpis_pkg::NPT_W-1:0];
          rpis_pkg::CFG_TLIM: tlim_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
      rdv_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            o_tc_r   <= '0;
            o_inl_r  <= 1'b0;
            o_best_r <= rpis_pkg::CNT_W'(best_r);
            o_st_r   <= rpis_pkg::ST_OK;
            case (op)
              rpis_pkg::OP_LOAD: begin
                out_v_r <= 1'b1;
                if (!idx_ok) begin
                  o_st_r <= rpis_pkg::ST_BAD;
                end
              end
              rpis_pkg::OP_TRIAL: begin
                if (trials_r >= tlim_r) begin
                  out_v_r <= 1'b1;
                  o_st_r  <= rpis_pkg::ST_LIMIT;
                end else if (smp_bad) begin
                  out_v_r <= 1'b1;
                  o_st_r  <= rpis_pkg::ST_BAD;
                end else begin
                  trials_r <= trials_r + 16'd1;
                  s1_r     <= s1_n;
                  s2_r     <= s2_n;
                  s3_r     <= s3_n;
                  rdc_r    <= 2'd0;
                  state_r  <= S_RD;
                end
              end
              rpis_pkg::OP_QUERY: begin
                if (idx_n >= nact) begin
                  out_v_r <= 1'b1;
                  o_st_r  <= rpis_pkg::ST_BAD;
                end else begin
                  state_r <= S_QRY;
                end
              end
              default: begin
                best_r   <= '0;
                trials_r <= '0;
                o_best_r <= '0;
                out_v_r  <= 1'b1;
              end
            endcase
          end
        end
        S_RD: begin
          // sample reads return in the cycle after their address
          rdc_r <= rdc_r + 2'd1;
          case (rdc_r)
            2'd1:    p1_r <= pt_rdata;
            2'd2:    p2_r <= pt_rdata;
            2'd3: begin
              p3_r    <= pt_rdata;
              state_r <= S_GO;
            end
            default: ;
          endcase
        end
        S_GO: begin
          state_r <= S_SET;
        end
        S_SET: begin
          if (su_done) begin
            wcnt_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          rdv_r  <= 1'b1;
          ridx_r <= wcnt_r;
          if (wcnt_r == LAST_A) begin
            state_r <= S_DRAIN;
          end else begin
            wcnt_r <= wcnt_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (po_v && (po_idx == LAST_A)) begin
            out_v_r <= 1'b1;
            o_tc_r  <= rpis_pkg::CNT_W'(tc_fin);
            o_inl_r <= 1'b0;
            o_st_r  <= rpis_pkg::ST_OK;
            if (tc_fin > best_r) begin
              best_r   <= tc_fin;
              bank_r   <= ~bank_r;
              o_best_r <= rpis_pkg::CNT_W'(tc_fin);
            end else begin
              o_best_r <= rpis_pkg::CNT_W'(best_r);
            end
            state_r <= S_IDLE;
          end
        end
        S_QRY: begin
          out_v_r <= 1'b1;
          o_inl_r <= (best_r != '0) && mk_rdata[bank_r];
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // count marks as they leave the pipeline
      if (po_v) begin
        cnt_r <= tc_fin;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, o_st_r, o_inl_r, o_best_r, o_tc_r};

  // a result never waits while a trial walks the store
  a_no_out_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> !out_v_r)
    else $error("result pending during trial walk");

  // marks are written back only by a trial walk
  a_mark_we: assert property (@(posedge clk) disable iff (!rst_n)
    mk_we |-> (state_r == S_WALK || state_r == S_DRAIN))
    else $error("mark write outside trial");

  a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
    best_r <= MAX_N)
    else $error("best count beyond store depth");

  // trial counter only steps by one or clears on start
  a_trials_step: assert property (@(posedge clk) disable iff (!rst_n)
    (trials_r != $past(trials_r)) |->
      (trials_r == $past(trials_r) + 16'd1 || trials_r == '0))
    else $error("trial counter jumped");

endmodule
